// ----- rtl/ple_pkg.sv -----
// Shared types and constants for the positional list engine.
package ple_pkg;

    localparam int unsigned CAPACITY_DEF = 16;

    localparam int unsigned IDX_MAX_W = 8;
    localparam int unsigned CNT_MAX_W = 9;

    localparam int unsigned KIND_W    = 3;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned FPOS_W    = 4;
    localparam int unsigned ECNT_W    = 5;
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 48;

    typedef enum logic [KIND_W-1:0] {
        KIND_INS_FRONT = 3'd0,
        KIND_INS_BACK  = 3'd1,
        KIND_INS_AT    = 3'd2,
        KIND_REMOVE_AT = 3'd3,
        KIND_FIND      = 3'd4,
        KIND_READ      = 3'd5,
        KIND_CLEAR     = 3'd6
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_POS   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        COP_NONE   = 3'd0,
        COP_INSERT = 3'd1,
        COP_REMOVE = 3'd2,
        COP_FIND   = 3'd3,
        COP_READ   = 3'd4
    } cell_op_t;

    typedef struct packed {
        logic                 act;
        cell_op_t             op;
        logic [IDX_MAX_W-1:0] pos;
        logic [CNT_MAX_W-1:0] lim;
        logic [VALUE_W-1:0]   data;
        logic                 hit;
        logic [IDX_MAX_W-1:0] hit_idx;
    } tok_t;

endpackage

// ----- rtl/ple_cell.sv -----
// One list cell: holds one entry and acts on the request token passing through.
module ple_cell import ple_pkg::*; #(
    parameter int unsigned INDEX = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tok_t               tok_in,
    input  logic [VALUE_W-1:0] next_entry,
    output tok_t               tok_out,
    output logic [VALUE_W-1:0] entry
);

    localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(INDEX);
    localparam logic [CNT_MAX_W-1:0] MY_CNT = CNT_MAX_W'(INDEX);

    logic [VALUE_W-1:0] entry_reg, entry_next;
    tok_t               tok_reg, tok_next;

    always_comb begin
        entry_next = entry_reg;
        tok_next   = tok_in;
        if (tok_in.act) begin
            unique case (tok_in.op)
                COP_INSERT: begin
                    if (MY_IDX >= tok_in.pos) begin
                        entry_next    = tok_in.data;
                        tok_next.data = entry_reg;
                    end
                end
                COP_REMOVE: begin
                    if (MY_IDX >= tok_in.pos) begin
                        entry_next = next_entry;
                    end
                end
                COP_FIND: begin
                    if (!tok_in.hit && (MY_CNT < tok_in.lim) && (entry_reg == tok_in.data)) begin
                        tok_next.hit     = 1'b1;
                        tok_next.hit_idx = MY_IDX;
                    end
                end
                COP_READ: begin
                    if (MY_IDX == tok_in.pos) begin
                        tok_next.data = entry_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.act <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign entry   = entry_reg;

endmodule

// ----- rtl/positional_list_engine.sv -----
// Top level of the positional list engine: request decode, cell chain and result register.
//
//  channel | ports                            | contents
//  --------+----------------------------------+-------------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser | tuser: kind; tdata: position, value
//  result  | m_tvalid m_tready m_tdata        | tdata: status, read_value, found_position,
//          |                                  |        entry_count, is_empty
//
// A request runs down the row of CAPACITY cells, one cell a cycle; one item is
// in flight at a time.
// Reset empties the list; entries keep no reset value.
// A new request is taken while the previous result waits in the output register.
module positional_list_engine import ple_pkg::*; #(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // position[4:0], value[36:5], zero pad
    input  logic [KIND_W-1:0]    s_tuser,   // kind[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status[1:0], read_value[33:2],
                                            // found_position[37:34], entry_count[42:38],
                                            // is_empty[43], zero pad
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_MAX_W-1:0] CAP_EXT = CNT_MAX_W'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg;
    tok_t                 tok_issue_reg;
    status_t              stat_reg;
    logic                 find_reg;
    logic                 read_reg;
    logic [M_TDATA_W-1:0] res_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tvalid_reg;

    tok_t                 chain [CAPACITY+1];
    logic [VALUE_W-1:0]   ent   [CAPACITY];

    logic [POS_W-1:0]     s_position;
    logic [VALUE_W-1:0]   s_value;
    logic                 s_xfer;
    logic                 m_free;

    logic [CNT_MAX_W-1:0] cnt_ext;
    logic [CNT_MAX_W-1:0] pos_ext;
    cell_op_t             iss_op;
    logic [CNT_MAX_W-1:0] iss_pos;
    status_t              iss_stat;
    logic [CNT_MAX_W-1:0] cnt_new;

    tok_t                 fin;
    status_t              res_stat;
    logic [VALUE_W-1:0]   res_value;
    logic [FPOS_W-1:0]    res_fpos;
    logic [M_TDATA_W-1:0] res_next;

    assign s_position = s_tdata[POS_W-1:0];
    assign s_value    = s_tdata[POS_W+VALUE_W-1:POS_W];
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_xfer     = s_tvalid && s_tready;
    assign m_free     = !m_tvalid_reg || m_tready;

    assign cnt_ext = CNT_MAX_W'(count_reg);
    assign pos_ext = CNT_MAX_W'(s_position);

    always_comb begin
        logic [CNT_MAX_W-1:0] ins_pos;
        ins_pos  = pos_ext;
        iss_op   = COP_NONE;
        iss_pos  = pos_ext;
        iss_stat = STAT_OK;
        cnt_new  = cnt_ext;
        unique case (kind_t'(s_tuser))
            KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
                if (kind_t'(s_tuser) == KIND_INS_FRONT) begin
                    ins_pos = '0;
                end else if (kind_t'(s_tuser) == KIND_INS_BACK) begin
                    ins_pos = cnt_ext;
                end
                if (ins_pos > cnt_ext) begin
                    iss_stat = STAT_BAD_POS;
                end else if (cnt_ext == CAP_EXT) begin
                    iss_stat = STAT_FULL;
                end else begin
                    iss_op  = COP_INSERT;
                    iss_pos = ins_pos;
                    cnt_new = cnt_ext + CNT_MAX_W'(1);
                end
            end
            KIND_REMOVE_AT: begin
                if (pos_ext >= cnt_ext) begin
                    iss_stat = STAT_BAD_POS;
                end else begin
                    iss_op  = COP_REMOVE;
                    cnt_new = cnt_ext - CNT_MAX_W'(1);
                end
            end
            KIND_FIND: begin
                iss_op = COP_FIND;
            end
            KIND_READ: begin
                if (pos_ext >= cnt_ext) begin
                    iss_stat = STAT_BAD_POS;
                end else begin
                    iss_op = COP_READ;
                end
            end
            KIND_CLEAR: begin
                cnt_new = '0;
            end
            default: ;
        endcase
    end

    assign chain[0] = tok_issue_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [VALUE_W-1:0] nb;
            if (gi == CAPACITY - 1) begin : g_last
                assign nb = '0;
            end else begin : g_mid
                assign nb = ent[gi+1];
            end
            ple_cell #(
                .INDEX (gi)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .tok_in     (chain[gi]),
                .next_entry (nb),
                .tok_out    (chain[gi+1]),
                .entry      (ent[gi])
            );
        end
    endgenerate

    assign fin       = chain[CAPACITY];
    assign res_stat  = find_reg ? (fin.hit ? STAT_OK : STAT_NOT_FOUND) : stat_reg;
    assign res_value = read_reg ? fin.data : '0;
    assign res_fpos  = (find_reg && fin.hit) ? fin.hit_idx[FPOS_W-1:0] : '0;
    assign res_next  = {
        (M_TDATA_W - STATUS_W - VALUE_W - FPOS_W - ECNT_W - 1)'(0),
        (count_reg == '0),
        cnt_ext[ECNT_W-1:0],
        res_fpos,
        res_value,
        res_stat
    };

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_xfer) state_next = ST_RUN;
            ST_RUN:  if (fin.act) state_next = ST_HOLD;
            ST_HOLD: if (m_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            count_reg         <= '0;
            tok_issue_reg.act <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            tok_issue_reg.act <= s_xfer;
            if (s_xfer) begin
                count_reg             <= cnt_new[CNT_W-1:0];
                tok_issue_reg.op      <= iss_op;
                tok_issue_reg.pos     <= iss_pos[IDX_MAX_W-1:0];
                tok_issue_reg.lim     <= cnt_ext;
                tok_issue_reg.data    <= s_value;
                tok_issue_reg.hit     <= 1'b0;
                tok_issue_reg.hit_idx <= '0;
            end
            if ((state_reg == ST_HOLD) && m_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            stat_reg <= iss_stat;
            find_reg <= (iss_op == COP_FIND);
            read_reg <= (iss_op == COP_READ);
        end
        if (fin.act) begin
            res_reg <= res_next;
        end
        if ((state_reg == ST_HOLD) && m_free) begin
            m_tdata_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- dv/positional_list_engine_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the positional list engine: request stream against a shadow list.
module positional_list_engine_test import ple_pkg::*;;

    localparam int unsigned CAP = CAPACITY_DEF;
    localparam int unsigned LATENCY = CAP + 3;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
    localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        status_t             status;
        logic [VALUE_W-1:0]  read_value;
        logic [FPOS_W-1:0]   found_position;
        logic [ECNT_W-1:0]   entry_count;
        logic                is_empty;
    } list_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [VALUE_W-1:0] list_cells [CAP];
    int unsigned        list_len = 0;
    bit                 growing = 1'b1;

    list_result_t pending_results [$];
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  idle_pct = 0;
    int unsigned  stall_pct = 0;
    int unsigned  hold_request = 0;
    int unsigned  hold_left = 0;

    positional_list_engine #(.CAPACITY(CAP)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("positional_list_engine_test: done, errors");
            $finish;
        end
    end

    function automatic status_t list_insert(int unsigned at, logic [VALUE_W-1:0] value);
        if (at > list_len)
            return STAT_BAD_POS;
        if (list_len >= CAP)
            return STAT_FULL;
        for (int unsigned i = list_len; i > at; i--)
            list_cells[i] = list_cells[i-1];
        list_cells[at] = value;
        list_len++;
        return STAT_OK;
    endfunction

    function automatic list_result_t list_apply(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                                logic [VALUE_W-1:0] value);
        list_result_t res;
        res = '0;
        res.status = STAT_OK;
        case (kind)
            KIND_INS_FRONT: res.status = list_insert(0, value);
            KIND_INS_BACK:  res.status = list_insert(list_len, value);
            KIND_INS_AT:    res.status = list_insert(pos, value);
            KIND_REMOVE_AT: begin
                if (pos >= list_len) begin
                    res.status = STAT_BAD_POS;
                end else begin
                    for (int unsigned i = pos; i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i+1];
                    list_len--;
                end
            end
            KIND_FIND: begin
                res.status = STAT_NOT_FOUND;
                for (int unsigned i = 0; i < list_len; i++) begin
                    if (list_cells[i] == value) begin
                        res.status = STAT_OK;
                        res.found_position = i[FPOS_W-1:0];
                        break;
                    end
                end
            end
            KIND_READ: begin
                if (pos < list_len)
                    res.read_value = list_cells[pos];
                else
                    res.status = STAT_BAD_POS;
            end
            KIND_CLEAR: list_len = 0;
            default: ;
        endcase
        res.entry_count = list_len[ECNT_W-1:0];
        res.is_empty = (list_len == 0);
        return res;
    endfunction

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [VALUE_W-1:0] value);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {3'b000, value, pos};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(list_apply(kind, pos, value));
    endtask

    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding: m_tdata=%h", m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
                check_field("read_value", want.read_value, m_tdata[33:2]);
                check_field("found_position", 32'(want.found_position), 32'(m_tdata[37:34]));
                check_field("entry_count", 32'(want.entry_count), 32'(m_tdata[42:38]));
                check_field("is_empty", 32'(want.is_empty), 32'(m_tdata[43]));
            end
        end
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return 32'($urandom_range(7)) - 32'd4;
            1: return (list_len != 0) ? list_cells[$urandom_range(list_len - 1)] : $urandom;
            2: return $urandom_range(1) ? VAL_MIN : VAL_MAX;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_list();
        send_request(KIND_READ, 5'd0, 32'd0);
        send_request(KIND_REMOVE_AT, 5'd0, 32'd0);
        send_request(KIND_FIND, 5'd0, 32'd0);
        send_request(KIND_UNUSED, 5'd31, 32'hFFFF_FFFF);
        send_request(KIND_INS_AT, 5'd1, 32'd5);
    endtask

    task automatic test_fill_to_capacity();
        send_request(KIND_INS_FRONT, 5'd0, VAL_MIN);
        send_request(KIND_INS_BACK, 5'd0, VAL_MAX);
        send_request(KIND_INS_AT, 5'd1, 32'd0);
        send_request(KIND_INS_BACK, 5'd0, 32'hFFFF_FFFF);
        for (int i = 0; i < 12; i++)
            send_request(KIND_INS_AT, 5'((i * 7) % (i + 5)), (i == 6) ? 32'd0 : $urandom);
        send_request(KIND_INS_BACK, 5'd0, 32'd1);
        send_request(KIND_INS_AT, 5'd17, 32'd1);
    endtask

    task automatic test_lookup_and_remove();
        send_request(KIND_FIND, 5'd0, 32'd0);
        send_request(KIND_READ, 5'd15, 32'd0);
        send_request(KIND_REMOVE_AT, 5'd15, 32'd0);
        send_request(KIND_READ, 5'd15, 32'd0);
        send_request(KIND_READ, 5'd31, 32'd0);
        send_request(KIND_REMOVE_AT, 5'd0, 32'd0);
        send_request(KIND_CLEAR, 5'd0, 32'd0);
    endtask

    task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
                                     input int unsigned n_items);
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        int unsigned       r;
        idle_pct = idle;
        stall_pct = stall;
        for (int unsigned n = 0; n < n_items; n++) begin
            if (list_len == 0)
                growing = 1'b1;
            else if (list_len == CAP && $urandom_range(3) == 0)
                growing = 1'b0;
            r = $urandom_range(99);
            if (growing)
                kind = (r < 25) ? KIND_INS_FRONT : (r < 50) ? KIND_INS_BACK :
                       (r < 70) ? KIND_INS_AT : (r < 78) ? KIND_REMOVE_AT :
                       (r < 88) ? KIND_FIND : (r < 97) ? KIND_READ :
                       (r < 99) ? KIND_UNUSED : KIND_CLEAR;
            else
                kind = (r < 8) ? KIND_INS_FRONT : (r < 16) ? KIND_INS_BACK :
                       (r < 24) ? KIND_INS_AT : (r < 60) ? KIND_REMOVE_AT :
                       (r < 75) ? KIND_FIND : (r < 94) ? KIND_READ :
                       (r < 97) ? KIND_UNUSED : KIND_CLEAR;
            if ($urandom_range(99) < 85)
                pos = 5'($urandom_range(list_len));
            else
                pos = 5'($urandom_range(31));
            send_request(kind, pos, pick_value());
        end
    endtask

    task automatic test_output_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_request = 300;
        for (int i = 0; i < 24; i++)
            send_request((i % 3 == 0) ? KIND_READ : KIND_INS_BACK,
                         5'($urandom_range(list_len)), $urandom);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_list();
        test_fill_to_capacity();
        test_lookup_and_remove();
        test_random_phase(0, 0, 320);
        test_random_phase(68, 0, 320);
        test_random_phase(0, 68, 320);
        test_random_phase(31, 31, 320);
        test_output_backpressure();
        drain_results();
        if (error_count == 0)
            $display("positional_list_engine_test: done, clean");
        else
            $display("positional_list_engine_test: done, errors");
        $finish;
    end

endmodule
